// ===== design/cfq_pkg.sv =====
// Shared types, codes and constants for the CAN frame queue.
package cfq_pkg;

  // Default number of frames the ring holds
  localparam int RING_DEPTH_DEF = 64;

  localparam int ID_W      = 29;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int HELD_W    = 7;
  localparam int MAX_LEN   = 8;

  // Request codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_SEND  = 1'b1;

  // Message types
  localparam logic [2:0] MSG_STD_DATA   = 3'd0;
  localparam logic [2:0] MSG_EXT_DATA   = 3'd1;
  localparam logic [2:0] MSG_STD_REMOTE = 3'd2;
  localparam logic [2:0] MSG_EXT_REMOTE = 3'd3;
  localparam logic [2:0] MSG_BUS_STATE  = 3'd4;

  // Bus-off bit of the controller state byte
  localparam int BUS_OFF_BIT = 7;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_BUS_STATE = 2'd3
  } status_t;

  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_READ = 1'b1
  } front_state_t;

  // One command from the front end to the byte emitter
  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic               ext;
    logic               rtr;
    logic [LEN_W-1:0]   len;
    logic [ID_W-1:0]    id;
    logic [DATA_W-1:0]  data;
    logic               bus_off;
    logic [HELD_W-1:0]  held;
  } cmd_t;

endpackage

// ===== design/cfq_front.sv =====
// Front end: accepts requests, keeps the frame ring and issues commands.
module cfq_front #(
  parameter int RING_DEPTH = cfq_pkg::RING_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [2:0]                msg_type,
  input  logic [cfq_pkg::ID_W-1:0]  can_id,
  input  logic [3:0]                data_length,
  input  logic [63:0]               payload,
  input  logic [7:0]                bus_state,
  input  logic                      q_full,
  output logic                      q_push,
  output cfq_pkg::cmd_t             q_cmd
);
  import cfq_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(RING_DEPTH);

  localparam int INFO_W = ID_W + 2 + LEN_W;

  front_state_t state, state_next;

  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [CW-1:0] count, count_next;
  logic          bus_off_flag, bus_off_flag_next;

  logic [INFO_W-1:0] info_mem [RING_DEPTH];
  logic [DATA_W-1:0] data_mem [RING_DEPTH];
  logic [INFO_W-1:0] rd_info;
  logic [DATA_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [INFO_W-1:0] wr_info;

  logic              accept;
  logic [LEN_W-1:0]  sat_len;
  logic [CW+HELD_W-1:0] cnt_wide;

  assign in_ready = (state == FS_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign sat_len  = (data_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : data_length;
  assign wr_info  = {sat_len, msg_type[1], msg_type[0], can_id};

  // Advance the request state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: if (accept && action == ACT_SEND && count != '0) state_next = FS_READ;
      FS_READ: state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  // Classify the request, update the ring and build the command
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    count_next         = count;
    bus_off_flag_next  = bus_off_flag;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    q_push             = 1'b0;
    q_cmd              = '0;
    q_cmd.kind         = KIND_STATUS;
    q_cmd.status       = ST_STORED;
    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          q_push = 1'b1;
          if (action == ACT_STORE) begin
            if (msg_type == MSG_BUS_STATE) begin
              if (bus_state[BUS_OFF_BIT]) bus_off_flag_next = 1'b1;
              q_cmd.status = ST_BUS_STATE;
            end else if (msg_type > MSG_EXT_REMOTE) begin
              q_cmd.status = ST_IGNORED;
            end else if (count == CNT_FULL) begin
              q_cmd.status = ST_DROPPED;
            end else begin
              mem_we             = 1'b1;
              write_pointer_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
              count_next         = count + 1'b1;
            end
          end else if (count == '0) begin
            q_cmd.kind = KIND_EMPTY;
          end else begin
            // Frame goes out once the ring read returns
            q_push            = 1'b0;
            mem_re            = 1'b1;
            read_pointer_next = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
            count_next        = count - 1'b1;
          end
        end
      end
      FS_READ: begin
        q_push     = 1'b1;
        q_cmd.kind = KIND_FRAME;
        q_cmd.id   = rd_info[ID_W-1:0];
        q_cmd.ext  = rd_info[ID_W];
        q_cmd.rtr  = rd_info[ID_W+1];
        q_cmd.len  = rd_info[INFO_W-1 -: LEN_W];
        q_cmd.data = rd_data;
      end
      default: ;
    endcase
    cnt_wide      = {{HELD_W{1'b0}}, count_next};
    q_cmd.held    = cnt_wide[HELD_W-1:0];
    q_cmd.bus_off = bus_off_flag_next;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FS_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      count         <= '0;
      bus_off_flag  <= 1'b0;
    end else begin
      state         <= state_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      count         <= count_next;
      bus_off_flag  <= bus_off_flag_next;
    end
  end

  // Frame ring write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      info_mem[write_pointer] <= wr_info;
      data_mem[write_pointer] <= payload;
    end
  end

  // Frame ring read port, registered
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_info <= info_mem[read_pointer];
      rd_data <= data_mem[read_pointer];
    end
  end

endmodule

// ===== design/cfq_queue.sv =====
// Two-entry command queue between the front end and the byte emitter.
module cfq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cfq_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cfq_pkg::cmd_t  head_cmd
);
  import cfq_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = entry[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/cfq_back.sv =====
// Back end: turns queued commands into result beats, one per cycle while the output is not stalled.
module cfq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  cfq_pkg::cmd_t               head_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [1:0]                  store_status,
  output logic [7:0]                  frame_byte,
  output logic                        last_byte,
  output logic                        bus_off,
  output logic [cfq_pkg::HELD_W-1:0]  frames_held
);
  import cfq_pkg::*;

  cmd_t             cur;
  logic             busy;
  logic [3:0]       idx;
  logic             emit;
  logic [7:0]       beat_byte;
  logic             beat_last;
  logic             beat_done;
  logic [3:0]       last_idx;
  logic [2:0]       data_sel;

  assign pop      = head_valid && !busy;
  assign emit     = busy && (!out_valid || out_ready);
  assign last_idx = 4'd4 + cur.len;
  assign data_sel = 3'(idx - 4'd5);

  // Select the frame byte at the current index
  always_comb begin
    beat_byte = 8'd0;
    unique case (idx)
      4'd0: beat_byte = cur.ext ? cur.id[28:21] : 8'd0;
      4'd1: beat_byte = cur.ext ? {cur.id[20:18], 1'b0, 2'b11, cur.id[17:16]} : 8'd0;
      4'd2: beat_byte = cur.ext ? cur.id[15:8] : {5'd0, cur.id[10:8]};
      4'd3: beat_byte = cur.id[7:0];
      4'd4: beat_byte = {3'd0, cur.len, cur.rtr};
      default: beat_byte = cur.data[{data_sel, 3'b000} +: 8];
    endcase
    beat_last = (cur.kind == KIND_FRAME) && (idx == last_idx);
    beat_done = (cur.kind != KIND_FRAME) || beat_last;
    if (cur.kind != KIND_FRAME) beat_byte = 8'd0;
  end

  // Load commands and step through their beats
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 4'd0;
    end else if (emit) begin
      idx <= idx + 1'b1;
      if (beat_done) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_cmd;
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= cur.kind;
      store_status <= cur.status;
      frame_byte   <= beat_byte;
      last_byte    <= beat_last;
      bus_off      <= cur.bus_off;
      frames_held  <= cur.held;
    end
  end

endmodule

// ===== design/can_to_udp_frame_queue.sv =====
// Top level of the CAN frame queue: front end, command queue, byte emitter.
// A store request gives one status beat. A send request on a non-empty
// ring holds the front end in its read state for the registered ring
// read, and then gives 5 + length beats (5 to 13), one per cycle from the
// byte emitter while out_ready allows; a send on an empty ring gives one
// beat. The byte emitter sets the sustained rate: it loads each command
// from the queue before emitting its beats and takes no new command
// until its last beat is emitted. A two-entry command queue lets the
// front end take further requests while a frame streams out.
// The ring holds RING_DEPTH frames in two memories (header fields and data)
// and needs no clearing after reset.
module can_to_udp_frame_queue #(
  parameter int RING_DEPTH = cfq_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [2:0]                  msg_type,
  input  logic [28:0]                 can_id,
  input  logic [3:0]                  data_length,
  input  logic [63:0]                 payload,
  input  logic [7:0]                  bus_state,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [1:0]                  store_status,
  output logic [7:0]                  frame_byte,
  output logic                        last_byte,
  output logic                        bus_off,
  output logic [cfq_pkg::HELD_W-1:0]  frames_held
);
  import cfq_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_in, q_head;

  cfq_front #(.RING_DEPTH(RING_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .msg_type    (msg_type),
    .can_id      (can_id),
    .data_length (data_length),
    .payload     (payload),
    .bus_state   (bus_state),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  cfq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  cfq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head_cmd     (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .store_status (store_status),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte),
    .bus_off      (bus_off),
    .frames_held  (frames_held)
  );

endmodule

// ===== design/cfq_checker.sv =====
// Port-level checks for the CAN frame queue, bound to the top level.
module cfq_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [1:0] store_status,
  input logic [7:0] frame_byte,
  input logic       last_byte,
  input logic       bus_off,
  input logic [6:0] frames_held
);
  import cfq_pkg::*;

  logic seen_bus_off;

  // Remember a bus-off beat once delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_bus_off <= 1'b0;
    end else if (out_valid && out_ready && bus_off) begin
      seen_bus_off <= 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("stalled result beat changed");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_bus_off |-> bus_off)
    else $error("bus-off flag cleared");

  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> kind == KIND_FRAME)
    else $error("last byte marked on a non-frame beat");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> frames_held == 7'd0 && store_status == ST_STORED)
    else $error("empty-queue beat with frames held");

endmodule

bind can_to_udp_frame_queue cfq_checker u_cfq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .store_status (store_status),
  .frame_byte   (frame_byte),
  .last_byte    (last_byte),
  .bus_off      (bus_off),
  .frames_held  (frames_held)
);
